>>> hdl/swmb_pkg.sv
// Shared types and constants of the strided window mean blur.
// Used by the front, queue, back and top-level files; depends on nothing.
package swmb_pkg;

    // Coordinate fields are 9 bits wide, so centres span 0 .. 511
    localparam int COORD_W    = 9;
    localparam int COORD_SPAN = 512;
    localparam int CHAN_W     = 8;
    localparam int PIXEL_W    = 24;
    localparam int CFG_W      = 10;

    // Stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Configuration register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // Request kinds as carried in tuser
    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } t_kind;

    // One queued request
    typedef struct packed {
        t_kind                kind;
        logic [COORD_W-1:0]   col;
        logic [COORD_W-1:0]   row;
        logic [PIXEL_W-1:0]   pixel;   // {red, green, blue}
    } t_entry;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_DIVIDE,
        ST_DONE
    } t_state;

endpackage

>>> hdl/swmb_ram.sv
// Generic single-port RAM with registered read data.
// Stand-alone; used by the back end as the frame store.
module swmb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 262144
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on enable, read the same address every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/swmb_queue.sv
// Short request queue that decouples the front from the back end.
// Depends on swmb_pkg for the entry type and depth.
module swmb_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  swmb_pkg::t_entry i_entry,
    input  logic             i_pop,
    output swmb_pkg::t_entry o_entry,
    output logic             o_full,
    output logic             o_empty
);

    swmb_pkg::t_entry                r_slot [swmb_pkg::QUEUE_DEPTH];
    logic [swmb_pkg::QUEUE_AW-1:0]   r_wr_ptr;
    logic [swmb_pkg::QUEUE_AW-1:0]   r_rd_ptr;
    logic [swmb_pkg::QUEUE_AW:0]     r_count;

    assign o_full  = (r_count == (swmb_pkg::QUEUE_AW + 1)'(swmb_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_slot[r_rd_ptr];

    // Store pushed requests
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hdl/swmb_front.sv
// Front end: accepts stream requests, drops writes outside the image
// and queues the rest. Depends on swmb_pkg.
module swmb_front #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // column[8:0], row[17:9], red_in[25:18], green_in[33:26], blue_in[41:34]
    input  logic [swmb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // command[0]
    input  logic                              s_axis_tuser,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]    i_eff_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]   i_eff_h,
    input  logic                              i_full,
    output logic                              o_push,
    output swmb_pkg::t_entry                  o_entry
);

    logic in_image;
    logic accept;

    assign s_axis_tready = !i_full;
    assign accept        = s_axis_tvalid && !i_full;

    // Unpack the request
    assign o_entry.kind  = swmb_pkg::t_kind'(s_axis_tuser);
    assign o_entry.col   = s_axis_tdata[8:0];
    assign o_entry.row   = s_axis_tdata[17:9];
    assign o_entry.pixel = {s_axis_tdata[25:18], s_axis_tdata[33:26], s_axis_tdata[41:34]};

    // Writes outside the configured image are dropped here
    assign in_image = (32'(o_entry.col) < 32'(i_eff_w)) && (32'(o_entry.row) < 32'(i_eff_h));
    assign o_push   = accept && ((o_entry.kind == swmb_pkg::KIND_QUERY) || in_image);

endmodule

>>> hdl/swmb_back.sv
// Back end: carries out queued writes and queries against the frame store,
// accumulates the sample grid, divides and holds the result. Uses swmb_pkg, swmb_ram.
module swmb_back #(
    parameter int MAX_WIDTH     = 512,
    parameter int MAX_HEIGHT    = 512,
    parameter int WINDOW_REACH  = 20,
    parameter int SAMPLE_STRIDE = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]    i_eff_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]   i_eff_h,
    input  logic                              i_empty,
    input  swmb_pkg::t_entry                  i_entry,
    output logic                              o_pop,
    output logic                              o_tvalid,
    input  logic                              i_tready,
    output logic [swmb_pkg::OUT_TDATA_W-1:0]  o_tdata
);

    localparam int TAPS  = 2 * WINDOW_REACH / SAMPLE_STRIDE + 1;
    localparam int NS    = TAPS * TAPS;
    localparam int SUMW  = $clog2(255 * NS + 1);
    // Reciprocal of the sample count, exact for every sum up to 255 * NS
    localparam int     RS = 8 + 2 * $clog2(NS);
    localparam longint RM = ((longint'(1) << RS) + longint'(NS) - 1) / longint'(NS);
    localparam int     MW = $clog2(RM + 1);
    localparam int     PW = SUMW + MW;
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int XEW   = $clog2(MAX_WIDTH + 1);
    localparam int YEW   = $clog2(MAX_HEIGHT + 1);
    localparam int SPANW = $clog2(swmb_pkg::COORD_SPAN + WINDOW_REACH + 1);
    localparam int CW0   = (SPANW > XEW) ? SPANW : XEW;
    localparam int CW    = ((CW0 > YEW) ? CW0 : YEW) + 1;
    localparam int KW    = $clog2(TAPS + 1);

    swmb_pkg::t_state r_state, n_state;
    swmb_pkg::t_entry r_entry;

    logic [KW-1:0]             r_kx, r_ky;
    logic signed [CW-1:0]      r_dx, r_dy;
    logic [XW-1:0]             r_x;
    logic [YW-1:0]             r_y;
    logic                      r_v1, r_v2;
    logic [SUMW-1:0]           r_sum  [3];
    logic [swmb_pkg::CHAN_W-1:0] r_quot [3];
    logic                      r_out_valid;
    logic [swmb_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic                      pop;
    logic                      ram_we;
    logic                      load_out;
    logic                      scan_last;
    logic [AW-1:0]             wr_addr, rd_addr, ram_addr;
    logic [swmb_pkg::PIXEL_W-1:0] ram_rdata;
    logic signed [CW-1:0]      sx, sy;

    // Clamp a signed coordinate into 0 .. size - 1
    function automatic logic [CW-1:0] clamp(input logic signed [CW-1:0] v,
                                            input logic signed [CW-1:0] size);
        logic [CW-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v >= size) begin
            res = CW'(size - 1);
        end else begin
            res = CW'(v);
        end
        return res;
    endfunction

    // Sample coordinates before clamping
    assign sx = $signed(CW'(r_entry.col)) + r_dx;
    assign sy = $signed(CW'(r_entry.row)) + r_dy;
    assign scan_last = (r_kx == KW'(TAPS - 1)) && (r_ky == KW'(TAPS - 1));

    // Frame store addressing: row-major with a fixed pitch
    assign wr_addr  = AW'(YW'(r_entry.row)) * AW'(MAX_WIDTH) + AW'(XW'(r_entry.col));
    assign rd_addr  = AW'(r_y) * AW'(MAX_WIDTH) + AW'(r_x);
    assign ram_addr = ram_we ? wr_addr : rd_addr;

    swmb_ram #(
        .WIDTH (swmb_pkg::PIXEL_W),
        .DEPTH (MAX_WIDTH * MAX_HEIGHT)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_entry.pixel),
        .o_rdata (ram_rdata)
    );

    // Next state and controls
    always_comb begin
        n_state  = r_state;
        pop      = 1'b0;
        ram_we   = 1'b0;
        load_out = 1'b0;
        case (r_state)
            swmb_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    pop = 1'b1;
                    n_state = (i_entry.kind == swmb_pkg::KIND_QUERY) ?
                              swmb_pkg::ST_SCAN : swmb_pkg::ST_WRITE;
                end
            end
            swmb_pkg::ST_WRITE: begin
                ram_we  = 1'b1;
                n_state = swmb_pkg::ST_IDLE;
            end
            swmb_pkg::ST_SCAN: begin
                if (scan_last) begin
                    n_state = swmb_pkg::ST_DRAIN;
                end
            end
            swmb_pkg::ST_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = swmb_pkg::ST_DIVIDE;
                end
            end
            swmb_pkg::ST_DIVIDE: begin
                n_state = swmb_pkg::ST_DONE;
            end
            swmb_pkg::ST_DONE: begin
                if (!r_out_valid || i_tready) begin
                    load_out = 1'b1;
                    n_state  = swmb_pkg::ST_IDLE;
                end
            end
            default: n_state = swmb_pkg::ST_IDLE;
        endcase
    end

    assign o_pop = pop;

    // State register, pipeline valids and result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swmb_pkg::ST_IDLE;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == swmb_pkg::ST_SCAN);
            r_v2    <= r_v1;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath: latch request, walk the grid, accumulate, divide
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_entry <= i_entry;
            r_kx    <= '0;
            r_ky    <= '0;
            r_dx    <= -$signed(CW'(WINDOW_REACH));
            r_dy    <= -$signed(CW'(WINDOW_REACH));
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= '0;
            end
        end
        if (r_state == swmb_pkg::ST_SCAN) begin
            r_x <= XW'(clamp(sx, $signed(CW'(i_eff_w))));
            r_y <= YW'(clamp(sy, $signed(CW'(i_eff_h))));
            if (r_kx == KW'(TAPS - 1)) begin
                r_kx <= '0;
                r_dx <= -$signed(CW'(WINDOW_REACH));
                r_ky <= r_ky + 1'b1;
                r_dy <= r_dy + $signed(CW'(SAMPLE_STRIDE));
            end else begin
                r_kx <= r_kx + 1'b1;
                r_dx <= r_dx + $signed(CW'(SAMPLE_STRIDE));
            end
        end
        if (r_v2) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= r_sum[c] + SUMW'(ram_rdata[(2 - c) * 8 +: 8]);
            end
        end
        // Divide by the sample count: multiply by its reciprocal and shift
        if (r_state == swmb_pkg::ST_DIVIDE) begin
            for (int c = 0; c < 3; c++) begin
                r_quot[c] <= swmb_pkg::CHAN_W'((PW'(r_sum[c]) * PW'(RM)) >> RS);
            end
        end
        if (load_out) begin
            r_out_data <= {r_quot[2], r_quot[1], r_quot[0]};
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;

endmodule

>>> hdl/strided_window_mean_blur.sv
// Top level of the strided window mean blur: configuration registers,
// effective image size, and the front, queue and back instances. Uses swmb_pkg.
//
// Usage:
//   Requests enter on the s_axis stream. tuser = 0 writes one RGB pixel into the
//   frame store (ignored when outside the configured image); tuser = 1 queries
//   the mean of a TAPS x TAPS grid centred on the pixel, TAPS = 2*REACH/STRIDE+1
//   (9 x 9 = 81 samples by default), sample coordinates clamped to the image.
//   Each query yields one result on m_axis; writes yield none.
//   image_width / image_height are written through i_cfg_* while idle;
//   0 counts as 1 and values above the maximum count as the maximum.
// Sequencing:
//   A write is taken from the queue and then written to the frame store. A query is
//   taken from the queue, then makes one frame-store read per sample through the
//   single RAM port, drains the read pipeline, multiplies by the reciprocal and
//   loads the output register. A four-entry queue takes requests while the back
//   end is busy.
// Reset and stall:
//   Synchronous active-low reset empties the queue, returns the sequencer to
//   idle and restores both sizes to 512; the frame store is not cleared.
//   While m_axis_tready is low the result is held, the back end waits after its
//   next query, and s_axis_tready drops once the queue is full.
module strided_window_mean_blur #(
    parameter int MAX_WIDTH     = 512,
    parameter int MAX_HEIGHT    = 512,
    parameter int WINDOW_REACH  = 20,
    parameter int SAMPLE_STRIDE = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // column[8:0], row[17:9], red_in[25:18], green_in[33:26], blue_in[41:34]
    input  logic [swmb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // command[0]
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // red_mean[7:0], green_mean[15:8], blue_mean[23:16]
    output logic [swmb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_addr,
    input  logic [swmb_pkg::CFG_W-1:0]        i_cfg_wdata
);

    localparam int XEW = $clog2(MAX_WIDTH + 1);
    localparam int YEW = $clog2(MAX_HEIGHT + 1);

    logic [swmb_pkg::CFG_W-1:0] r_image_width;
    logic [swmb_pkg::CFG_W-1:0] r_image_height;
    logic [XEW-1:0]             eff_w;
    logic [YEW-1:0]             eff_h;
    logic                       push, pop, full, empty;
    swmb_pkg::t_entry           push_entry, head_entry;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= 10'd512;
            r_image_height <= 10'd512;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                swmb_pkg::CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_wdata;
                swmb_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective sizes: zero counts as one, oversize saturates
    always_comb begin
        if (r_image_width == '0) begin
            eff_w = XEW'(1);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            eff_w = XEW'(MAX_WIDTH);
        end else begin
            eff_w = XEW'(r_image_width);
        end
        if (r_image_height == '0) begin
            eff_h = YEW'(1);
        end else if (32'(r_image_height) > MAX_HEIGHT) begin
            eff_h = YEW'(MAX_HEIGHT);
        end else begin
            eff_h = YEW'(r_image_height);
        end
    end

    swmb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_eff_w       (eff_w),
        .i_eff_h       (eff_h),
        .i_full        (full),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    swmb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_full  (full),
        .o_empty (empty)
    );

    swmb_back #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .WINDOW_REACH  (WINDOW_REACH),
        .SAMPLE_STRIDE (SAMPLE_STRIDE)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_eff_w  (eff_w),
        .i_eff_h  (eff_h),
        .i_empty  (empty),
        .i_entry  (head_entry),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata)
    );

endmodule
